// ===== design/scc_pkg.sv =====
// scc_pkg: shared constants and helpers for the scaled calendar clock
// register indexes, reset values, field widths; no dependencies

package scc_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_DAY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_HOUR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MINUTE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DAYS_PER_YEAR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DAYS_PER_MONTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DAY_COUNT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TICK_OF_DAY = 3'd6;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned TS_W       = 32;
	localparam int unsigned RES_W      = 104;

	// reset values of the registers
	localparam logic [31:0] RST_TICKS_PER_DAY    = 32'd86400000;
	localparam logic [31:0] RST_TICKS_PER_HOUR   = 32'd3600000;
	localparam logic [31:0] RST_TICKS_PER_MINUTE = 32'd60000;
	localparam logic [15:0] RST_DAYS_PER_YEAR    = 16'd360;
	localparam logic [15:0] RST_DAYS_PER_MONTH   = 16'd30;

	// a zero period acts as one
	function automatic logic [31:0] nz32(input logic [31:0] v);
		return (v == 32'd0) ? 32'd1 : v;
	endfunction

endpackage

// ===== design/scaled_calendar_clock.sv =====
// scaled_calendar_clock: calendar date and time from millisecond timestamps
// depends on scc_pkg; one shared restoring divider under a small sequencer
//
// channel  | dir | handshake                    | payload
// ---------+-----+------------------------------+-----------------------------------------
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: timestamp_ms; tuser: operation
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: year..minute, day_count, tick_of_day
// cfg      | in  | cfg_wen (no wait)            | cfg_index, cfg_wdata
//
// steps: a restart, first sample or zero-difference word runs the year, month, hour and minute
//   divisions; a word that advances the clock first adds the difference to the tick of day
//   and divides by the day length; the bit-per-cycle divider runs up to five divisions
// one word at a time: s_axis_tready is high only while idle and no finished result waits
// a finished result waits while the output register still holds an untaken word
// arst_n clears the counters, the reference and the sequencer, and arms the first-sample flag

module scaled_calendar_clock
	import scc_pkg::*;
#(
	parameter int unsigned TIMESTAMP_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample side
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TS_W-1:0]       s_axis_tdata,  // [31:0] timestamp_ms
	input  logic [0:0]            s_axis_tuser,  // [0] operation
	// result side
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] year, [15:8] month, [23:16] day, [31:24] hour, [39:32] minute,
	// [71:40] day_count, [103:72] tick_of_day
	output logic [RES_W-1:0]      m_axis_tdata,
	// configuration writes
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// dividend width of the day carry division (tick of day plus difference)
	localparam int unsigned W  = ((TIMESTAMP_BITS > 32) ? TIMESTAMP_BITS : 32) + 1;
	localparam int unsigned CW = $clog2(W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_DIV_DAY,
		ST_YEAR_LD,
		ST_DIV_YEAR,
		ST_DIV_MONTH,
		ST_DIV_HOUR,
		ST_DIV_MIN
	} state_t;

	// configuration registers
	logic [31:0] tpd_q, tph_q, tpm_q, sdc_q, stod_q;
	logic [15:0] dpy_q, dpm_q;

	// clock state
	logic [31:0]               day_q;
	logic [31:0]               tick_q;
	logic [TIMESTAMP_BITS-1:0] last_q;
	logic                      first_q;

	// sequencer and shared divider
	state_t        state_q;
	logic          done_q;      // all divisions finished, result waits for the output register
	logic [W-1:0]  quo_q;       // dividend shifts out at the top, quotient shifts in at the bottom
	logic [31:0]   rem_q;
	logic [31:0]   dvs_q;
	logic [CW-1:0] cnt_q;

	// calendar fields gathered along the way
	logic [7:0] year_q, month_q, dom_q, hour_q, minute_q;

	logic [TIMESTAMP_BITS-1:0] now;
	logic [TIMESTAMP_BITS-1:0] delta;
	logic [32:0]               rem_sh;
	logic [32:0]               rem_diff;
	logic                      rem_ge;
	logic [31:0]               rem_nx;
	logic                      s_acc;
	logic                      out_free;

	assign now   = TIMESTAMP_BITS'(s_axis_tdata);
	assign delta = now - last_q;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh   = {rem_q, quo_q[W-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign rem_ge   = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx   = rem_ge ? rem_diff[31:0] : rem_sh[31:0];

	assign s_axis_tready = (state_q == ST_IDLE) && !done_q;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	// configuration register file; the host writes it only between words, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpd_q  <= RST_TICKS_PER_DAY;
			tph_q  <= RST_TICKS_PER_HOUR;
			tpm_q  <= RST_TICKS_PER_MINUTE;
			dpy_q  <= RST_DAYS_PER_YEAR;
			dpm_q  <= RST_DAYS_PER_MONTH;
			sdc_q  <= 32'd0;
			stod_q <= 32'd0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_TICKS_PER_DAY:     tpd_q  <= cfg_wdata;
				CFG_TICKS_PER_HOUR:    tph_q  <= cfg_wdata;
				CFG_TICKS_PER_MINUTE:  tpm_q  <= cfg_wdata;
				CFG_DAYS_PER_YEAR:     dpy_q  <= cfg_wdata[15:0];
				CFG_DAYS_PER_MONTH:    dpm_q  <= cfg_wdata[15:0];
				CFG_START_DAY_COUNT:   sdc_q  <= cfg_wdata;
				CFG_START_TICK_OF_DAY: stod_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer, clock state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done_q        <= 1'b0;
			cnt_q         <= '0;
			day_q         <= '0;
			tick_q        <= '0;
			last_q        <= '0;
			first_q       <= 1'b1;
			m_axis_tvalid <= 1'b0;
		end else begin
			// hand the finished result to the output register
			if (done_q && out_free) begin
				m_axis_tdata  <= {tick_q, day_q, minute_q, hour_q, dom_q, month_q, year_q};
				m_axis_tvalid <= 1'b1;
				done_q        <= 1'b0;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_axis_tuser[0]) begin
							// restart from the start registers
							day_q   <= sdc_q;
							tick_q  <= stod_q;
							first_q <= 1'b1;
							state_q <= ST_YEAR_LD;
						end else if (first_q) begin
							// first sample only sets the reference
							last_q  <= now;
							first_q <= 1'b0;
							state_q <= ST_YEAR_LD;
						end else if (delta != '0) begin
							last_q  <= now;
							quo_q   <= W'(delta);
							state_q <= ST_ADD;
						end else begin
							state_q <= ST_YEAR_LD;
						end
					end
				end
				ST_ADD: begin
					// total ticks, divided once by the day length
					quo_q   <= quo_q + W'(tick_q);
					rem_q   <= '0;
					dvs_q   <= nz32(tpd_q);
					cnt_q   <= CW'(W);
					state_q <= ST_DIV_DAY;
				end
				ST_YEAR_LD: begin
					quo_q   <= {day_q, {(W-32){1'b0}}};
					rem_q   <= '0;
					dvs_q   <= nz32({16'd0, dpy_q});
					cnt_q   <= CW'(32);
					state_q <= ST_DIV_YEAR;
				end
				ST_DIV_DAY, ST_DIV_YEAR, ST_DIV_MONTH, ST_DIV_HOUR, ST_DIV_MIN: begin
					if (cnt_q != '0) begin
						quo_q <= {quo_q[W-2:0], rem_ge};
						rem_q <= rem_nx;
						cnt_q <= cnt_q - CW'(1);
					end else begin
						rem_q <= '0;
						unique case (state_q)
							ST_DIV_DAY: begin
								// whole days carry into the day count, which wraps
								day_q   <= day_q + quo_q[31:0];
								tick_q  <= rem_q;
								state_q <= ST_YEAR_LD;
							end
							ST_DIV_YEAR: begin
								year_q  <= quo_q[7:0] + 8'd1;
								// day of year is below days_per_year, so 16 bits hold it
								quo_q   <= {rem_q[15:0], {(W-16){1'b0}}};
								dvs_q   <= nz32({16'd0, dpm_q});
								cnt_q   <= CW'(16);
								state_q <= ST_DIV_MONTH;
							end
							ST_DIV_MONTH: begin
								month_q <= quo_q[7:0] + 8'd1;
								dom_q   <= rem_q[7:0] + 8'd1;
								quo_q   <= {tick_q, {(W-32){1'b0}}};
								dvs_q   <= nz32(tph_q);
								cnt_q   <= CW'(32);
								state_q <= ST_DIV_HOUR;
							end
							ST_DIV_HOUR: begin
								hour_q  <= quo_q[7:0];
								quo_q   <= {rem_q, {(W-32){1'b0}}};
								dvs_q   <= nz32(tpm_q);
								cnt_q   <= CW'(32);
								state_q <= ST_DIV_MIN;
							end
							default: begin
								minute_q <= quo_q[7:0];
								done_q   <= 1'b1;
								state_q  <= ST_IDLE;
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/scc_checker.sv =====
// scc_checker: port-level checks for scaled_calendar_clock
// depends on scc_pkg; attached to the top level by the bind at the end

module scc_checker
	import scc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [TS_W-1:0]       s_axis_tdata,
	input logic [0:0]            s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [RES_W-1:0]      m_axis_tdata,
	input logic                  cfg_wen,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// one word at a time: ready drops right after a word is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready while a word is in work");

	// ready comes back only together with a delivered result
	a_ready_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> m_axis_tvalid)
		else $error("ready returned without a result");

	// a new result appears exactly when the sequencer frees the input
	a_result_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $rose(s_axis_tready))
		else $error("result appeared without the input freeing");

endmodule

bind scaled_calendar_clock scc_checker u_scc_checker (.*);
